/* rtl/core/mcp_pkg.sv */
// mcp_pkg: shared types, codes and constant tables for the cell polygonizer
// holds the corner offsets, edge endpoints and the triangle list rows
// used by mcp_edge_lane, mcp_tri_merge and the top level
`timescale 1ns / 1ps
`default_nettype none
package mcp_pkg;

  localparam int NUM_EDGES = 12;
  localparam int NUM_CORNERS = 8;
  localparam int COORD_W = 15;
  localparam int ROW_CHARS = 15;

  localparam logic [1:0] MODE_P1 = 2'd0;
  localparam logic [1:0] MODE_P2 = 2'd1;
  localparam logic [1:0] MODE_FRAC = 2'd2;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } mcp_vtx_t;

  typedef struct packed {
    logic start;
    logic step;
  } mcp_lane_ctl_t;

  typedef struct packed {
    logic       start;
    logic [7:0] cube;
  } mcp_merge_ctl_t;

  typedef struct packed {
    logic [2:0]                ntri;
    logic [ROW_CHARS-1:0][3:0] edges;
  } mcp_row_t;

  // corner offsets {x, y, z}
  localparam logic [2:0] CORNER_OFF [NUM_CORNERS] = '{
    3'b001, 3'b101, 3'b100, 3'b000, 3'b011, 3'b111, 3'b110, 3'b010
  };

  localparam logic [2:0] EDGE_A [NUM_EDGES] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7, 3'd0, 3'd1, 3'd2, 3'd3
  };

  localparam logic [2:0] EDGE_B [NUM_EDGES] = '{
    3'd1, 3'd2, 3'd3, 3'd0, 3'd5, 3'd6, 3'd7, 3'd4, 3'd4, 3'd5, 3'd6, 3'd7
  };

  // triangle lists, one hex edge digit per character, three per triangle
  localparam logic [ROW_CHARS*8-1:0] TRI_ROWS [256] = '{
    "", "083", "019", "183981", "12a", "08312a", "92a029", "2832a8a98",
    "3b2", "0b28b0", "19023b", "1b219b98b", "3a1ba3", "0a108a8ba", "3903b9ba9", "98aa8b",
    "478", "430734", "019847", "419471731", "12a847", "34730412a", "92a902847", "2a9297273794",
    "8473b2", "b47b42204", "90184723b", "47b94b9b2921", "3a13ba784", "1ba14b1047b4",
    "47890b9bab03", "47b4b99ba",
    "954", "954083", "054150", "854835315", "12a954", "30812a495", "52a542402", "2a5325354348",
    "9543b2", "0b208b495", "05401523b", "21525828b485", "a3ba13954", "4950818a18ba",
    "54050b5bab03", "54858aa8b",
    "978579", "930953573", "078017157", "153357", "978957a12", "a12950530573", "802825857a52",
    "2a5253357",
    "7957893b2", "95797292027b", "23b018178157", "b21b17715", "958857a13a3b", "5705097b010aba0",
    "ba0b03a50807570", "ba57b5",
    "a65", "0835a6", "9015a6", "1831985a6", "165261", "165126308", "965906026", "598582526328",
    "23ba65", "b08b20a65", "01923b5a6", "5a61929b298b", "63b653513", "08b0b50515b6",
    "3b6036065059", "65969bb98",
    "5a6478", "43047365a", "1905a6847", "a65197173794", "612651478", "125526304347",
    "847905065026", "739794329596269",
    "3b2784a65", "5a647242027b", "01947823b5a6", "9219b294b7b45a6", "8473b53515b6",
    "51b5b610b7b404b", "059065036b63847", "65969b4797b9",
    "a4964a", "4a649a083", "a01a60640", "83181686461a", "149124264", "308129249264", "024426",
    "832824426",
    "a49a64b23", "08228b49a4a6", "3b201606461a", "64161a48121b8b1", "964936913b63",
    "8b1810b61914641", "3b6360064", "648b68",
    "7a678a89a", "0730a709a67a", "a671a7178180", "a67a71173", "126168189867", "269291679093739",
    "780706602", "732672",
    "23ba68a89867", "20727b09767a9a7", "1801781a767a23b", "b21b17a61671", "896867916b63136",
    "091b67", "7807063b0b60", "7b6",
    "76b", "308b76", "019b76", "819831b76", "a126b7", "12a3086b7", "2902a96b7", "6b72a3a83a98",
    "723627", "708760620", "276237019", "162186198876", "a76a17137", "a7617a187108",
    "03707a0a96a7", "76a7a88a9",
    "684b86", "36b306046", "86b846901", "946963931b36", "6846b82a1", "12a30b06b046",
    "4b846b0292a9", "a93a32943b36463",
    "823842462", "042462", "190234246438", "194142246", "8138618466a1", "a10a06604",
    "4634386a3039a93", "a946a4",
    "49576b", "083495b76", "50154076b", "b76834354315", "954a1276b", "6b712a083495",
    "76b54a42a402", "348354325a52b76",
    "723762549", "954086062687", "362376150540", "628687218485158", "954a16176137",
    "16a176107870954", "40a4a503a6a737a", "76a7a854a48a",
    "6956b9b89", "36b063056095", "0b805b01556b", "6b3635531", "12a95b9b8b56", "0b306b09656912a",
    "b85b56805a52025", "6b36352a3a53",
    "589528562382", "956960062", "158180568382628", "156216", "13616a386569896", "a10a06950560",
    "03856a", "a56",
    "b5a75b", "b5ab75830", "5b75ab190", "a75ab7981831", "b12b71751", "08312717572b",
    "9759279022b7", "75272b592328982",
    "25a235375", "820852875a25", "9015a35373a2", "982921872a25752", "135375", "087071175",
    "903935537", "987597",
    "5845a8ab8", "5045b05abb30", "01984a8aba45", "ab4a45b34941314", "2512852b8458",
    "04b0b345b2b151b", "0250592b5458b85", "9452b3",
    "25a352345384", "5a2524420", "3a235a385458019", "5a2524192942", "845853351", "045105",
    "845853905035", "945",
    "4b749b9ab", "0834979b79ab", "1ab1b414074b", "3143481a474bab4", "4b79b492b912",
    "9749b791b2b1083", "b74b42240", "b74b42834324",
    "29a279237749", "9a7974a27870207", "37a3a274a1a040a", "1a2874", "491417713", "491417081871",
    "403743", "487",
    "9a8ab8", "30939bb9a", "01a0a88ab", "31ab3a", "12b1b99b8", "30939b1292b9", "02b80b", "32b",
    "23828aa89", "9a2092", "23828a0181a8", "1a2", "138918", "091", "038", ""
  };

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 4'(c - 8'h57);
    end
    return v;
  endfunction

  function automatic mcp_row_t row_decode(input logic [7:0] cube);
    logic [ROW_CHARS*8-1:0] row;
    logic [3:0]             n;
    logic [3:0]             pos;
    mcp_row_t               r;
    row = TRI_ROWS[cube];
    n = 4'd0;
    r = '0;
    for (int k = 0; k < ROW_CHARS; k++) begin
      if (row[k*8 +: 8] != 8'h00) begin
        n = n + 4'd1;
      end
    end
    for (int j = 0; j < ROW_CHARS; j++) begin
      pos = 4'(n - 4'd1 - 4'(j));
      if (4'(j) < n) begin
        r.edges[j] = hex_val(row[pos*8 +: 8]);
      end
    end
    r.ntri = 3'(n / 3);
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/mcp_edge_lane.sv */
// mcp_edge_lane: vertex placement on one cube edge
// restoring divider, one fraction bit per step; uses mcp_pkg
`timescale 1ns / 1ps
`default_nettype none
module mcp_edge_lane #(
  parameter int EDGE_IDX = 0,
  parameter int FRAC_BITS = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire mcp_pkg::mcp_lane_ctl_t ctl,
  input  wire logic signed [15:0]    iso,
  input  wire logic signed [15:0]    da,
  input  wire logic signed [15:0]    db,
  input  wire logic [5:0]            cell_x,
  input  wire logic [5:0]            cell_y,
  input  wire logic [5:0]            cell_z,
  output mcp_pkg::mcp_vtx_t          vtx
);

  localparam int CW = (7 + FRAC_BITS > mcp_pkg::COORD_W) ? 7 + FRAC_BITS : mcp_pkg::COORD_W;
  localparam logic [2:0] OFF_A = mcp_pkg::CORNER_OFF[mcp_pkg::EDGE_A[EDGE_IDX]];
  localparam logic [2:0] OFF_B = mcp_pkg::CORNER_OFF[mcp_pkg::EDGE_B[EDGE_IDX]];

  logic [1:0]           mode_r, mode_nxt;
  logic                 sat_r, sat_nxt;
  logic [15:0]          rem_r, rem_nxt;
  logic [15:0]          den_r, den_nxt;
  logic [FRAC_BITS-1:0] q_r, q_nxt;

  logic signed [16:0] dn, dd;
  logic [15:0]        num_abs, den_abs;
  logic [16:0]        rem2;
  logic [FRAC_BITS-1:0] frac;
  logic [2:0]         off;
  logic [CW-1:0]      cx, cy, cz;

  always_comb begin
    dn = {iso[15], iso} - {da[15], da};
    dd = {db[15], db} - {da[15], da};
    num_abs = dn[16] ? 16'(-dn) : dn[15:0];
    den_abs = dd[16] ? 16'(-dd) : dd[15:0];
    rem2 = {rem_r, 1'b0};
    mode_nxt = mode_r;
    sat_nxt = sat_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    q_nxt = q_r;
    if (ctl.start) begin
      rem_nxt = num_abs;
      den_nxt = den_abs;
      q_nxt = '0;
      sat_nxt = (num_abs >= den_abs);
      if (iso == da || da == db) begin
        mode_nxt = mcp_pkg::MODE_P1;
      end else if (iso == db) begin
        mode_nxt = mcp_pkg::MODE_P2;
      end else begin
        mode_nxt = mcp_pkg::MODE_FRAC;
      end
    end else if (ctl.step) begin
      if (rem2 >= {1'b0, den_r}) begin
        rem_nxt = 16'(rem2 - {1'b0, den_r});
        q_nxt = {q_r[FRAC_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = rem2[15:0];
        q_nxt = {q_r[FRAC_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= mcp_pkg::MODE_P1;
      sat_r  <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      sat_r  <= sat_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  always_comb begin
    frac = sat_r ? '1 : q_r;
    off = (mode_r == mcp_pkg::MODE_P2) ? OFF_B : OFF_A;
    cx = CW'({1'b0, cell_x} + 7'(off[2])) << FRAC_BITS;
    cy = CW'({1'b0, cell_y} + 7'(off[1])) << FRAC_BITS;
    cz = CW'({1'b0, cell_z} + 7'(off[0])) << FRAC_BITS;
    if (mode_r == mcp_pkg::MODE_FRAC) begin
      if (OFF_B[2] && !OFF_A[2]) cx = cx + CW'(frac);
      if (!OFF_B[2] && OFF_A[2]) cx = cx - CW'(frac);
      if (OFF_B[1] && !OFF_A[1]) cy = cy + CW'(frac);
      if (!OFF_B[1] && OFF_A[1]) cy = cy - CW'(frac);
      if (OFF_B[0] && !OFF_A[0]) cz = cz + CW'(frac);
      if (!OFF_B[0] && OFF_A[0]) cz = cz - CW'(frac);
    end
    vtx.x = cx[mcp_pkg::COORD_W-1:0];
    vtx.y = cy[mcp_pkg::COORD_W-1:0];
    vtx.z = cz[mcp_pkg::COORD_W-1:0];
  end

endmodule
`default_nettype wire

/* rtl/core/mcp_tri_merge.sv */
// mcp_tri_merge: triangle list lookup and result register
// gathers lane vertices into triangles, one beat per cycle while out_stall is low; uses mcp_pkg
`timescale 1ns / 1ps
`default_nettype none
module mcp_tri_merge (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire mcp_pkg::mcp_merge_ctl_t ctl,
  input  wire mcp_pkg::mcp_vtx_t      vtx [mcp_pkg::NUM_EDGES],
  input  wire logic                   out_stall,
  output logic                        out_valid,
  output mcp_pkg::mcp_vtx_t           va,
  output mcp_pkg::mcp_vtx_t           vb,
  output mcp_pkg::mcp_vtx_t           vc,
  output logic                        last_tri,
  output logic                        done
);

  logic              active_r, active_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        tcnt_r, tcnt_nxt;
  logic [2:0]        ntri_r;
  logic [3:0]        edges_r [mcp_pkg::ROW_CHARS];
  mcp_pkg::mcp_vtx_t va_r, vb_r, vc_r;
  logic              last_r;
  mcp_pkg::mcp_row_t row;
  logic              consumed, can_load;
  logic [3:0]        bi;

  function automatic logic [3:0] edge_fix(input logic [3:0] e);
    return (e > 4'd11) ? 4'd0 : e;
  endfunction

  always_comb begin
    row = mcp_pkg::row_decode(ctl.cube);
    consumed = out_valid_r && !out_stall;
    can_load = active_r && (tcnt_r != ntri_r) && (!out_valid_r || !out_stall);
    done = active_r && (tcnt_r == ntri_r) && (!out_valid_r || consumed);
    bi = {tcnt_r, 1'b0} + {1'b0, tcnt_r};
    active_nxt = active_r;
    if (ctl.start) begin
      active_nxt = 1'b1;
    end else if (done) begin
      active_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    tcnt_nxt = tcnt_r;
    if (ctl.start) begin
      tcnt_nxt = 3'd0;
    end else if (can_load) begin
      tcnt_nxt = tcnt_r + 3'd1;
    end
    if (can_load) begin
      out_valid_nxt = 1'b1;
    end else if (consumed) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      tcnt_r      <= 3'd0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      tcnt_r      <= tcnt_nxt;
    end
    if (ctl.start) begin
      ntri_r <= row.ntri;
      for (int j = 0; j < mcp_pkg::ROW_CHARS; j++) begin
        edges_r[j] <= row.edges[j];
      end
    end
    if (can_load) begin
      va_r   <= vtx[edge_fix(edges_r[bi])];
      vb_r   <= vtx[edge_fix(edges_r[4'(bi + 4'd1)])];
      vc_r   <= vtx[edge_fix(edges_r[4'(bi + 4'd2)])];
      last_r <= (tcnt_r + 3'd1 == ntri_r);
    end
  end

  assign out_valid = out_valid_r;
  assign va = va_r;
  assign vb = vb_r;
  assign vc = vc_r;
  assign last_tri = last_r;

endmodule
`default_nettype wire

/* rtl/core/marching_cubes_cell_polygonizer_unit.sv */
// One grid cell in, zero to five triangle beats out. A cell is taken when in_stall is low;
// an edge lane per cube edge places its vertex, all lanes in parallel, each with a restoring divider
// that produces one fraction bit per cycle. The triangle stage then looks up the cell's
// triangle list and presents one triangle per cycle while out_stall is low on the out_
// channel (last flagged by out_last_tri). in_stall stays high while a cell occupies the
// block, through the division and until the last triangle beat is taken.
// Cells with no cut edge produce no beat. The iso threshold is written through cfg_wr_en.
`timescale 1ns / 1ps
`default_nettype none
module marching_cubes_cell_polygonizer_unit #(
  parameter int GRID_SIZE = 64,
  parameter int FRAC_BITS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic signed [15:0] cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [5:0]         in_cell_x,
  input  wire logic [5:0]         in_cell_y,
  input  wire logic [5:0]         in_cell_z,
  input  wire logic signed [15:0] in_dens_c0,
  input  wire logic signed [15:0] in_dens_c1,
  input  wire logic signed [15:0] in_dens_c2,
  input  wire logic signed [15:0] in_dens_c3,
  input  wire logic signed [15:0] in_dens_c4,
  input  wire logic signed [15:0] in_dens_c5,
  input  wire logic signed [15:0] in_dens_c6,
  input  wire logic signed [15:0] in_dens_c7,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [14:0]             out_va_x,
  output logic [14:0]             out_va_y,
  output logic [14:0]             out_va_z,
  output logic [14:0]             out_vb_x,
  output logic [14:0]             out_vb_y,
  output logic [14:0]             out_vb_z,
  output logic [14:0]             out_vc_x,
  output logic [14:0]             out_vc_y,
  output logic [14:0]             out_vc_z,
  output logic                    out_last_tri
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    div_cnt_r, div_cnt_nxt;
  logic signed [15:0]  iso_r;
  logic [7:0]          cube_r;
  logic [5:0]          cx_r, cy_r, cz_r;
  logic                in_acc;
  logic                div_end;
  logic signed [15:0]  dens [mcp_pkg::NUM_CORNERS];
  logic [7:0]          cube;

  mcp_pkg::mcp_lane_ctl_t  lane_ctl;
  mcp_pkg::mcp_merge_ctl_t merge_ctl;
  mcp_pkg::mcp_vtx_t       vtx [mcp_pkg::NUM_EDGES];
  mcp_pkg::mcp_vtx_t       va, vb, vc;
  logic                    merge_done;

  function automatic logic [5:0] clamp_cell(input logic [5:0] c);
    return (int'(c) > GRID_SIZE - 1) ? 6'(GRID_SIZE - 1) : c;
  endfunction

  always_comb begin
    dens[0] = in_dens_c0;
    dens[1] = in_dens_c1;
    dens[2] = in_dens_c2;
    dens[3] = in_dens_c3;
    dens[4] = in_dens_c4;
    dens[5] = in_dens_c5;
    dens[6] = in_dens_c6;
    dens[7] = in_dens_c7;
    for (int i = 0; i < mcp_pkg::NUM_CORNERS; i++) begin
      cube[i] = (dens[i] < iso_r);
    end
  end

  always_comb begin
    in_stall = (state_r != ST_IDLE);
    in_acc = in_valid && !in_stall;
    div_end = (div_cnt_r == CNT_W'(FRAC_BITS));
    lane_ctl.start = in_acc;
    lane_ctl.step = (state_r == ST_DIV) && !div_end;
    merge_ctl.start = (state_r == ST_DIV) && div_end;
    merge_ctl.cube = cube_r;
    state_nxt = state_r;
    div_cnt_nxt = div_cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_DIV;
          div_cnt_nxt = '0;
        end
      end
      ST_DIV: begin
        if (div_end) begin
          state_nxt = ST_EMIT;
        end else begin
          div_cnt_nxt = div_cnt_r + CNT_W'(1);
        end
      end
      ST_EMIT: begin
        if (merge_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      div_cnt_r <= '0;
      iso_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      div_cnt_r <= div_cnt_nxt;
      if (cfg_wr_en) begin
        iso_r <= cfg_wr_data;
      end
    end
    if (in_acc) begin
      cube_r <= cube;
      cx_r   <= clamp_cell(in_cell_x);
      cy_r   <= clamp_cell(in_cell_y);
      cz_r   <= clamp_cell(in_cell_z);
    end
  end

  for (genvar e = 0; e < mcp_pkg::NUM_EDGES; e++) begin : g_lane
    mcp_edge_lane #(
      .EDGE_IDX  (e),
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (lane_ctl),
      .iso    (iso_r),
      .da     (dens[mcp_pkg::EDGE_A[e]]),
      .db     (dens[mcp_pkg::EDGE_B[e]]),
      .cell_x (cx_r),
      .cell_y (cy_r),
      .cell_z (cz_r),
      .vtx    (vtx[e])
    );
  end

  mcp_tri_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (merge_ctl),
    .vtx       (vtx),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .va        (va),
    .vb        (vb),
    .vc        (vc),
    .last_tri  (out_last_tri),
    .done      (merge_done)
  );

  assign out_va_x = va.x;
  assign out_va_y = va.y;
  assign out_va_z = va.z;
  assign out_vb_x = vb.x;
  assign out_vb_y = vb.y;
  assign out_vb_z = vb.z;
  assign out_vc_x = vc.x;
  assign out_vc_y = vc.y;
  assign out_vc_z = vc.z;

`ifndef SYNTHESIS
  a_out_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == ST_EMIT)
    else $error("result beat outside emit phase");
  a_acc_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == ST_DIV && div_cnt_r == '0)
    else $error("accepted cell did not start division");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    div_cnt_r <= CNT_W'(FRAC_BITS))
    else $error("division step count overrun");
  a_done_emit: assert property (@(posedge clk) disable iff (!rst_n)
    merge_done |-> state_r == ST_EMIT)
    else $error("triangle stage finished outside emit phase");
`endif

endmodule
`default_nettype wire

/* tb/marching_cubes_cell_polygonizer_unit_tb.sv */
// testbench for marching_cubes_cell_polygonizer_unit: directed and random cells checked
// against a behavioral triangle predictor, with random idling, stalls and a long hold-off
// depends on mcp_pkg (corner, edge and triangle tables) and the unit rtl
`timescale 1ns / 1ps
module marching_cubes_cell_polygonizer_unit_tb;

  localparam int UNIT = 256;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [5:0]        cx;
    logic [5:0]        cy;
    logic [5:0]        cz;
    logic [7:0][15:0]  dens;
  } cell_t;

  typedef struct packed {
    logic [8:0][14:0] coord;
    logic             last;
  } tri_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic signed [15:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [5:0] in_cell_x = '0, in_cell_y = '0, in_cell_z = '0;
  logic signed [15:0] in_dens_c0 = '0, in_dens_c1 = '0, in_dens_c2 = '0, in_dens_c3 = '0;
  logic signed [15:0] in_dens_c4 = '0, in_dens_c5 = '0, in_dens_c6 = '0, in_dens_c7 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [14:0] out_va_x, out_va_y, out_va_z, out_vb_x, out_vb_y, out_vb_z;
  logic [14:0] out_vc_x, out_vc_y, out_vc_z;
  logic out_last_tri;

  marching_cubes_cell_polygonizer_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_cell_x(in_cell_x), .in_cell_y(in_cell_y), .in_cell_z(in_cell_z),
    .in_dens_c0(in_dens_c0), .in_dens_c1(in_dens_c1), .in_dens_c2(in_dens_c2),
    .in_dens_c3(in_dens_c3), .in_dens_c4(in_dens_c4), .in_dens_c5(in_dens_c5),
    .in_dens_c6(in_dens_c6), .in_dens_c7(in_dens_c7),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_va_x(out_va_x), .out_va_y(out_va_y), .out_va_z(out_va_z),
    .out_vb_x(out_vb_x), .out_vb_y(out_vb_y), .out_vb_z(out_vb_z),
    .out_vc_x(out_vc_x), .out_vc_y(out_vc_y), .out_vc_z(out_vc_z),
    .out_last_tri(out_last_tri)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  cell_t cell_queue[$];
  tri_t  tri_queue[$];
  logic signed [15:0] iso_shadow = '0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;
  int hold_req = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int cells_sent = 0;
  int tris_seen = 0;
  logic in_fire = 1'b0;
  string coord_name[9] = '{"va_x", "va_y", "va_z", "vb_x", "vb_y", "vb_z",
                           "vc_x", "vc_y", "vc_z"};

  function automatic logic [44:0] edge_vertex(input int e, input int bx, input int by,
                                              input int bz, input int d[8], input int iso);
    int a, b, num, den, q;
    int p[3];
    int base[3];
    logic [2:0] oa, ob;
    a = mcp_pkg::EDGE_A[e];
    b = mcp_pkg::EDGE_B[e];
    oa = mcp_pkg::CORNER_OFF[a];
    ob = mcp_pkg::CORNER_OFF[b];
    base = '{bx, by, bz};
    for (int k = 0; k < 3; k++) p[k] = base[k] + oa[2-k] * UNIT;
    if (iso != d[a]) begin
      if (iso == d[b]) begin
        for (int k = 0; k < 3; k++) p[k] = base[k] + ob[2-k] * UNIT;
      end else if (d[a] != d[b]) begin
        num = iso - d[a];
        if (num < 0) num = -num;
        den = d[b] - d[a];
        if (den < 0) den = -den;
        q = (num * UNIT) / den;
        if (q >= UNIT) q = UNIT - 1;
        for (int k = 0; k < 3; k++) begin
          if (ob[2-k] > oa[2-k]) p[k] += q;
          else if (ob[2-k] < oa[2-k]) p[k] -= q;
        end
      end
    end
    return {p[0][14:0], p[1][14:0], p[2][14:0]};
  endfunction

  task automatic predict_triangles(input cell_t c);
    int d[8];
    int iso, cube, nchar, ntri;
    logic [mcp_pkg::ROW_CHARS*8-1:0] row;
    logic [7:0] ch;
    int e;
    tri_t t;
    iso = iso_shadow;
    cube = 0;
    for (int i = 0; i < 8; i++) begin
      d[i] = $signed(c.dens[i]);
      if (d[i] < iso) cube |= 1 << i;
    end
    row = mcp_pkg::TRI_ROWS[cube];
    nchar = 0;
    for (int k = 0; k < mcp_pkg::ROW_CHARS; k++) if (row[k*8 +: 8] != 8'h00) nchar++;
    ntri = nchar / 3;
    for (int ti = 0; ti < ntri; ti++) begin
      for (int v = 0; v < 3; v++) begin
        ch = row[(nchar - 1 - (ti * 3 + v)) * 8 +: 8];
        e = (ch >= "a") ? ch - "a" + 10 : ch - "0";
        {t.coord[8-v*3], t.coord[7-v*3], t.coord[6-v*3]} =
          edge_vertex(e, c.cx * UNIT, c.cy * UNIT, c.cz * UNIT, d, iso);
      end
      t.last = (ti + 1 == ntri);
      tri_queue = {tri_queue, t};
    end
  endtask

  // accept side: prediction on each input beat, check on each result beat
  always @(posedge clk) begin
    cell_t c;
    tri_t exp_tri;
    logic [8:0][14:0] got;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
    in_fire <= in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      c.cx = in_cell_x;
      c.cy = in_cell_y;
      c.cz = in_cell_z;
      c.dens = {in_dens_c7, in_dens_c6, in_dens_c5, in_dens_c4,
                in_dens_c3, in_dens_c2, in_dens_c1, in_dens_c0};
      predict_triangles(c);
      cells_sent++;
    end
    if (rst_n && out_valid && !out_stall) begin
      tris_seen++;
      if (tri_queue.size() == 0) begin
        $error("unexpected triangle beat");
        fail_count++;
      end else begin
        exp_tri = tri_queue.pop_front();
        got = {out_vc_z, out_vc_y, out_vc_x, out_vb_z, out_vb_y, out_vb_x,
               out_va_z, out_va_y, out_va_x};
        for (int i = 0; i < 9; i++) begin
          if (got[i] !== exp_tri.coord[8-i]) begin
            $error("%s: expected %0d, got %0d", coord_name[i], exp_tri.coord[8-i], got[i]);
            fail_count++;
          end
        end
        if (out_last_tri !== exp_tri.last) begin
          $error("last_tri: expected %0d, got %0d", exp_tri.last, out_last_tri);
          fail_count++;
        end
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (cell_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
        cell_t c;
        c = cell_queue.pop_front();
        in_cell_x <= c.cx;
        in_cell_y <= c.cy;
        in_cell_z <= c.cz;
        {in_dens_c7, in_dens_c6, in_dens_c5, in_dens_c4,
         in_dens_c3, in_dens_c2, in_dens_c1, in_dens_c0} <= c.dens;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_req > 0 && hold_cycles == 0) begin
      hold_cycles <= hold_req;
      hold_req <= 0;
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic [15:0] clamp16(input int v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic cell_t random_cell(input int iso);
    cell_t c;
    int mask, kind, spread;
    c.cx = 6'($urandom_range(63));
    c.cy = 6'($urandom_range(63));
    c.cz = 6'($urandom_range(63));
    kind = $urandom_range(9);
    mask = $urandom_range(255);
    spread = ($urandom_range(1)) ? 40 : 4000;
    for (int i = 0; i < 8; i++) begin
      if (kind < 2) begin
        c.dens[i] = 16'($urandom);
      end else if (kind < 4 && $urandom_range(3) == 0) begin
        c.dens[i] = clamp16(iso);
      end else if (mask[i]) begin
        c.dens[i] = clamp16(iso - 1 - $urandom_range(spread));
      end else begin
        c.dens[i] = clamp16(iso + $urandom_range(spread));
      end
    end
    return c;
  endfunction

  function automatic cell_t make_cell(input int cx, input int cy, input int cz,
                                      input logic [7:0][15:0] dens);
    cell_t c;
    c.cx = 6'(cx);
    c.cy = 6'(cy);
    c.cz = 6'(cz);
    c.dens = dens;
    return c;
  endfunction

  task automatic enqueue_cell(input cell_t c);
    cell_queue = {cell_queue, c};
  endtask

  task automatic wait_idle();
    while (cell_queue.size() > 0 || in_valid || tri_queue.size() > 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_iso(input logic signed [15:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    iso_shadow = v;
  endtask

  task automatic run_phase(input logic signed [15:0] iso, input int n, input int idle,
                           input int stall, input int hold);
    wait_idle();
    write_iso(iso);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) enqueue_cell(random_cell(iso));
    if (hold > 0) begin
      @(negedge clk);
      hold_req = hold;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset iso of zero: empty cells, extremes, single corners, exact-level corners
    enqueue_cell(make_cell(0, 0, 0, {8{16'sh7fff}}));
    enqueue_cell(make_cell(63, 63, 63, {8{16'sh8000}}));
    enqueue_cell(make_cell(63, 0, 63, {16'sh7fff, {6{16'sh7fff}}, 16'sh8000}));
    enqueue_cell(make_cell(0, 63, 0, {16'sh8000, {6{16'sh8000}}, 16'sh7fff}));
    for (int i = 0; i < 8; i++) begin
      logic [7:0][15:0] d;
      d = {8{16'sd100}};
      d[i] = -16'sd50;
      enqueue_cell(make_cell(i * 9, 63 - i, i, d));
    end
    enqueue_cell(make_cell(5, 6, 7, {16'sd0, 16'sd0, 16'sd0, 16'sd0,
                                     16'sd0, 16'sd0, 16'sd0, -16'sd1}));
    enqueue_cell(make_cell(5, 6, 7, {16'sd3, 16'sd0, 16'sd3, 16'sd0,
                                     16'sd3, 16'sd0, 16'sd3, -16'sd5}));
    enqueue_cell(make_cell(1, 2, 3, {-16'sd7, -16'sd7, 16'sd9, 16'sd9,
                                     -16'sd7, -16'sd7, 16'sd9, -16'sd7}));
    enqueue_cell(make_cell(1, 2, 3, {16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                                     16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff}));
    enqueue_cell(make_cell(42, 21, 10, {16'sd1, -16'sd1, 16'sd2, -16'sd2,
                                        16'sd300, -16'sd300, 16'sd1, -16'sd255}));
    enqueue_cell(make_cell(63, 63, 63, {16'sd5, -16'sd5, -16'sd5, 16'sd5,
                                        -16'sd5, 16'sd5, 16'sd5, -16'sd5}));

    run_phase(16'sd0, 20, 0, 0, 0);
    run_phase(16'sd100, 20, 65, 0, 0);
    run_phase(16'sh7fff, 8, 0, 65, 0);
    run_phase(16'sh8000, 4, 0, 0, 0);
    run_phase(-16'sd1234, 20, 0, 0, 300);
    run_phase($urandom, 20, 35, 35, 0);
    run_phase(16'sd0, 15, 0, 0, 0);

    wait_idle();
    $display("covered %0d cells and %0d triangle beats over seven threshold phases",
             cells_sent, tris_seen);
    $display("with extremes, exact-level corners, idles, stalls and a long hold-off");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
